/* sv/alusf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// alusf_pkg: shared types and constants for the 8-bit ALU
// Operation codes, status bit positions and the command and result words.
// ----------------------------------------------------------------------------
package alusf_pkg;

  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_ADC   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_SBC   = 5'd3;
  localparam logic [4:0] OP_CP    = 5'd4;
  localparam logic [4:0] OP_CPC   = 5'd5;
  localparam logic [4:0] OP_AND   = 5'd6;
  localparam logic [4:0] OP_OR    = 5'd7;
  localparam logic [4:0] OP_EOR   = 5'd8;
  localparam logic [4:0] OP_COM   = 5'd9;
  localparam logic [4:0] OP_NEG   = 5'd10;
  localparam logic [4:0] OP_INC   = 5'd11;
  localparam logic [4:0] OP_DEC   = 5'd12;
  localparam logic [4:0] OP_LSR   = 5'd13;
  localparam logic [4:0] OP_ASR   = 5'd14;
  localparam logic [4:0] OP_ROR   = 5'd15;
  localparam logic [4:0] OP_SWAP  = 5'd16;
  localparam logic [4:0] OP_ADIW  = 5'd17;
  localparam logic [4:0] OP_SBIW  = 5'd18;
  localparam logic [4:0] OP_MUL   = 5'd19;
  localparam logic [4:0] OP_MULS  = 5'd20;
  localparam logic [4:0] OP_MULSU = 5'd21;
  localparam logic [4:0] OP_FMUL  = 5'd22;

  // Status byte bit positions.
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_N = 2;
  localparam int FLAG_V = 3;
  localparam int FLAG_S = 4;
  localparam int FLAG_H = 5;
  localparam int FLAG_T = 6;
  localparam int FLAG_I = 7;

  typedef struct packed {
    logic [4:0]  operation;
    logic [15:0] operand_a;
    logic [7:0]  operand_b;
    logic [7:0]  status_in;
  } alu_in_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [7:0]  status_out;
    logic        writes_result;
    logic        result_is_word;
  } alu_out_t;

endpackage
`default_nettype wire

/* sv/alusf_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// alusf_core: combinational ALU datapath
// Computes the result, the new status byte and the write and word marks for
// one command word.
// ----------------------------------------------------------------------------
module alusf_core (
  input  wire alusf_pkg::alu_in_t cmd,
  output alusf_pkg::alu_out_t     res
);

  logic [4:0]  op;
  logic [15:0] aw;
  logic [7:0]  d;
  logic [7:0]  r;
  logic [7:0]  sr_in;
  logic        cin;
  logic        c_use;
  logic [8:0]  add9;
  logic [4:0]  addh5;
  logic [8:0]  sub9;
  logic [4:0]  subh5;
  logic [7:0]  neg8;
  logic [15:0] wsum;
  logic [15:0] wdiff;
  logic [8:0]  mul_a;
  logic [8:0]  mul_b;
  logic [17:0] prod;
  logic [15:0] prod16;
  logic [15:0] fprod;

  logic [7:0]  res8;
  logic [15:0] res16;
  logic [7:0]  sr;
  logic        wr;
  logic        word;

  function automatic logic [7:0] nzsv8(input logic [7:0] s_in, input logic [7:0] value,
                                       input logic v);
    logic [7:0] s;
    s = s_in;
    s[alusf_pkg::FLAG_N] = value[7];
    s[alusf_pkg::FLAG_Z] = (value == 8'h00);
    s[alusf_pkg::FLAG_V] = v;
    s[alusf_pkg::FLAG_S] = value[7] ^ v;
    return s;
  endfunction

  assign op    = cmd.operation;
  assign aw    = cmd.operand_a;
  assign d     = cmd.operand_a[7:0];
  assign r     = cmd.operand_b;
  assign sr_in = cmd.status_in;
  assign cin   = cmd.status_in[alusf_pkg::FLAG_C];

  assign c_use = ((op == alusf_pkg::OP_ADC) || (op == alusf_pkg::OP_SBC) ||
                  (op == alusf_pkg::OP_CPC)) ? cin : 1'b0;

  // Bit 8 of the nine-bit difference is the borrow out; bit 4 of the
  // five-bit nibble difference is the half borrow.
  assign add9  = {1'b0, d} + {1'b0, r} + {8'b0, c_use};
  assign addh5 = {1'b0, d[3:0]} + {1'b0, r[3:0]} + {4'b0, c_use};
  assign sub9  = {1'b0, d} - {1'b0, r} - {8'b0, c_use};
  assign subh5 = {1'b0, d[3:0]} - {1'b0, r[3:0]} - {4'b0, c_use};
  assign neg8  = 8'h00 - d;
  assign wsum  = aw + {10'b0, r[5:0]};
  assign wdiff = aw - {10'b0, r[5:0]};

  // One signed 9x9 multiplier covers all four multiply flavors.
  assign mul_a  = {((op == alusf_pkg::OP_MULS) || (op == alusf_pkg::OP_MULSU)) & d[7], d};
  assign mul_b  = {(op == alusf_pkg::OP_MULS) & r[7], r};
  assign prod   = 18'($signed(mul_a) * $signed(mul_b));
  assign prod16 = prod[15:0];
  assign fprod  = {prod16[14:0], 1'b0};

  always_comb begin
    res8  = 8'h00;
    res16 = 16'h0000;
    sr    = sr_in;
    wr    = 1'b1;
    word  = 1'b0;
    unique case (op) inside
      alusf_pkg::OP_ADD, alusf_pkg::OP_ADC: begin
        res8 = add9[7:0];
        sr = nzsv8(sr_in, res8, (d[7] & r[7] & ~res8[7]) | (~d[7] & ~r[7] & res8[7]));
        sr[alusf_pkg::FLAG_C] = add9[8];
        sr[alusf_pkg::FLAG_H] = addh5[4];
      end
      alusf_pkg::OP_SUB, alusf_pkg::OP_SBC, alusf_pkg::OP_CP, alusf_pkg::OP_CPC: begin
        res8 = sub9[7:0];
        sr = nzsv8(sr_in, res8, (d[7] & ~r[7] & ~res8[7]) | (~d[7] & r[7] & res8[7]));
        if ((op == alusf_pkg::OP_SBC) || (op == alusf_pkg::OP_CPC)) begin
          sr[alusf_pkg::FLAG_Z] = (res8 == 8'h00) & sr_in[alusf_pkg::FLAG_Z];
        end
        sr[alusf_pkg::FLAG_C] = sub9[8];
        sr[alusf_pkg::FLAG_H] = subh5[4];
        wr = (op == alusf_pkg::OP_SUB) || (op == alusf_pkg::OP_SBC);
      end
      alusf_pkg::OP_AND, alusf_pkg::OP_OR, alusf_pkg::OP_EOR, alusf_pkg::OP_COM: begin
        case (op)
          alusf_pkg::OP_AND: res8 = d & r;
          alusf_pkg::OP_OR:  res8 = d | r;
          alusf_pkg::OP_EOR: res8 = d ^ r;
          default:           res8 = ~d;
        endcase
        sr = nzsv8(sr_in, res8, 1'b0);
        if (op == alusf_pkg::OP_COM) begin
          sr[alusf_pkg::FLAG_C] = 1'b1;
        end
      end
      alusf_pkg::OP_NEG: begin
        res8 = neg8;
        sr = nzsv8(sr_in, res8, res8 == 8'h80);
        sr[alusf_pkg::FLAG_C] = (res8 != 8'h00);
        sr[alusf_pkg::FLAG_H] = res8[3] | d[3];
      end
      alusf_pkg::OP_INC: begin
        res8 = d + 8'h01;
        sr = nzsv8(sr_in, res8, res8 == 8'h80);
      end
      alusf_pkg::OP_DEC: begin
        res8 = d - 8'h01;
        sr = nzsv8(sr_in, res8, res8 == 8'h7F);
      end
      alusf_pkg::OP_LSR, alusf_pkg::OP_ASR, alusf_pkg::OP_ROR: begin
        case (op)
          alusf_pkg::OP_ASR: res8 = {d[7], d[7:1]};
          alusf_pkg::OP_ROR: res8 = {cin, d[7:1]};
          default:           res8 = {1'b0, d[7:1]};
        endcase
        // V is N xor C, so S = N xor V reduces to the shifted-out bit.
        sr = nzsv8(sr_in, res8, res8[7] ^ d[0]);
        sr[alusf_pkg::FLAG_C] = d[0];
      end
      alusf_pkg::OP_SWAP: begin
        res8 = {d[3:0], d[7:4]};
      end
      alusf_pkg::OP_ADIW, alusf_pkg::OP_SBIW: begin
        word = 1'b1;
        if (op == alusf_pkg::OP_ADIW) begin
          res16 = wsum;
          sr[alusf_pkg::FLAG_V] = ~aw[15] & res16[15];
          sr[alusf_pkg::FLAG_C] = aw[15] & ~res16[15];
        end else begin
          res16 = wdiff;
          sr[alusf_pkg::FLAG_V] = aw[15] & ~res16[15];
          sr[alusf_pkg::FLAG_C] = ~aw[15] & res16[15];
        end
        sr[alusf_pkg::FLAG_N] = res16[15];
        sr[alusf_pkg::FLAG_Z] = (res16 == 16'h0000);
        sr[alusf_pkg::FLAG_S] = res16[15] ^ sr[alusf_pkg::FLAG_V];
      end
      alusf_pkg::OP_MUL, alusf_pkg::OP_MULS, alusf_pkg::OP_MULSU, alusf_pkg::OP_FMUL: begin
        word = 1'b1;
        res16 = (op == alusf_pkg::OP_FMUL) ? fprod : prod16;
        sr[alusf_pkg::FLAG_C] = prod16[15];
        sr[alusf_pkg::FLAG_Z] = (res16 == 16'h0000);
      end
      default: begin
        wr = 1'b0;
      end
    endcase
  end

  assign res.result_value   = word ? res16 : {8'h00, res8};
  assign res.status_out     = sr;
  assign res.writes_result  = wr;
  assign res.result_is_word = word;

endmodule
`default_nettype wire

/* sv/avr_alu_with_status_flags.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avr_alu_with_status_flags: 8-bit ALU with status byte
// Registered command word, one pass through the ALU datapath, registered
// result word with a one-cycle done strobe.
// ----------------------------------------------------------------------------
// A command word is taken at every clock edge where start is high; busy is
// never raised, so a new word may follow in every cycle. Each word gives
// exactly one result word: it passes through the command register, then
// through the ALU logic into the result register. The result is on the
// result port for one cycle only, marked by done, and must be captured
// then; the receiver has no way to hold it.
module avr_alu_with_status_flags (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire alusf_pkg::alu_in_t cmd,
  output logic                   done,
  output alusf_pkg::alu_out_t    result
);

  alusf_pkg::alu_in_t  item;
  logic                item_valid;
  alusf_pkg::alu_out_t core_res;

  assign busy = 1'b0;

  alusf_core u_core (
    .cmd (item),
    .res (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      item_valid <= start;
      done       <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      item <= cmd;
    end
    result <= core_res;
  end

  // Every registered command word turns into a strobed result next cycle.
  a_valid_to_done: assert property (@(posedge clk) disable iff (rst)
    item_valid |=> done)
    else $error("accepted word did not produce a result");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !item_valid |=> !done)
    else $error("result strobe without a word in flight");

  // I and T are never touched by any operation.
  a_it_passthrough: assert property (@(posedge clk) disable iff (rst)
    item_valid |=> result.status_out[7:6] == $past(item.status_in[7:6]))
    else $error("I or T flag changed");

  a_byte_upper_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.result_is_word |-> result.result_value[15:8] == 8'h00)
    else $error("byte result has nonzero upper byte");

  a_start_to_valid: assert property (@(posedge clk) disable iff (rst)
    start |=> item_valid)
    else $error("command word not registered");

endmodule
`default_nettype wire
